// ===== sv/pcft_pkg.sv =====
// ----------------------------------------------------------------------------
// pcft_pkg
// Shared types and codes for the truncated cone point classifier.
// ----------------------------------------------------------------------------
package pcft_pkg;

    typedef enum logic [1:0] {
        REGION_INSIDE  = 2'd0,
        REGION_BEFORE  = 2'd1,
        REGION_PAST    = 2'd2,
        REGION_OUTSIDE = 2'd3
    } t_region;

    typedef enum logic [2:0] {
        CFG_END0_X       = 3'd0,
        CFG_END0_Y       = 3'd1,
        CFG_END0_Z       = 3'd2,
        CFG_END1_X       = 3'd3,
        CFG_END1_Y       = 3'd4,
        CFG_END1_Z       = 3'd5,
        CFG_RADIUS_START = 3'd6,
        CFG_RADIUS_END   = 3'd7
    } t_cfg_idx;

    // axial decisions, travelling alongside the radial datapath
    typedef struct packed {
        logic zero_axis;
        logic behind;
        logic past;
    } t_flags;

    localparam int unsigned MUL_CHUNK = 32;

endpackage

// ===== sv/point_in_cone_frustum_test.sv =====
// Throughput: one point per cycle; the whole pipeline holds while the output
// register is full and stalled.
// Reset clears the valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
// point_in_cone_frustum_test
// Classifies points against a truncated cone using exact squared integer
// comparisons through a nine-stage pipeline.
// ----------------------------------------------------------------------------
module point_in_cone_frustum_test #(
    parameter int unsigned COORD_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_region
);
    import pcft_pkg::*;

    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned DW  = 2 * W + 4;
    localparam int unsigned CW  = 2 * W + 3;
    localparam int unsigned SQW = 2 * CW;
    localparam int unsigned CRW = 2 * CW + 2;
    localparam int unsigned HUW = DW - 1;
    localparam int unsigned RUW = W - 1;
    localparam int unsigned RW  = RUW + HUW;
    localparam int unsigned LW  = CRW + HUW;
    localparam int unsigned R2W = 2 * RW;

    // configuration
    logic signed [W-1:0]    r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z;
    logic [RUW-1:0]         r_r0, r_r1;
    logic                   wr_en;
    t_cfg_idx               cfg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg_idx = t_cfg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0x <= '0;
            r_e0y <= '0;
            r_e0z <= '0;
            r_e1x <= '0;
            r_e1y <= '0;
            r_e1z <= '0;
            r_r0  <= '0;
            r_r1  <= '0;
        end else if (wr_en) begin
            case (cfg_idx)
                CFG_END0_X:       r_e0x <= pwdata[W-1:0];
                CFG_END0_Y:       r_e0y <= pwdata[W-1:0];
                CFG_END0_Z:       r_e0z <= pwdata[W-1:0];
                CFG_END1_X:       r_e1x <= pwdata[W-1:0];
                CFG_END1_Y:       r_e1y <= pwdata[W-1:0];
                CFG_END1_Z:       r_e1z <= pwdata[W-1:0];
                CFG_RADIUS_START: r_r0  <= pwdata[RUW-1:0];
                CFG_RADIUS_END:   r_r1  <= pwdata[RUW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_END0_X:       prdata = 32'(unsigned'(r_e0x));
            CFG_END0_Y:       prdata = 32'(unsigned'(r_e0y));
            CFG_END0_Z:       prdata = 32'(unsigned'(r_e0z));
            CFG_END1_X:       prdata = 32'(unsigned'(r_e1x));
            CFG_END1_Y:       prdata = 32'(unsigned'(r_e1y));
            CFG_END1_Z:       prdata = 32'(unsigned'(r_e1z));
            CFG_RADIUS_START: prdata = 32'(r_r0);
            CFG_RADIUS_END:   prdata = 32'(r_r1);
            default:          prdata = '0;
        endcase
    end

    // pipeline control
    logic en;
    logic r_out_valid;
    t_region r_region;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_region    = r_region;

    // stages A..C
    logic                   vc, zero_c;
    logic signed [DW-1:0]   d_c, h2_c;
    logic signed [CW-1:0]   cx_c, cy_c, cz_c;

    pcft_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_pz    (i_point_z),
        .i_e0x   (r_e0x),
        .i_e0y   (r_e0y),
        .i_e0z   (r_e0z),
        .i_e1x   (r_e1x),
        .i_e1y   (r_e1y),
        .i_e1z   (r_e1z),
        .o_valid (vc),
        .o_zero  (zero_c),
        .o_d     (d_c),
        .o_h2    (h2_c),
        .o_cx    (cx_c),
        .o_cy    (cy_c),
        .o_cz    (cz_c)
    );

    // stages D..E: squares of the cross product and radius terms
    logic [CW-1:0]      ax, ay, az;
    logic [SQW-1:0]     sq_x, sq_y, sq_z;
    logic signed [W-1:0] delta;
    logic [RUW-1:0]     delta_mag;
    logic [RW-1:0]      r0h2, rdd;
    t_flags             fl_c;

    assign ax = cx_c[CW-1] ? CW'(-cx_c) : CW'(cx_c);
    assign ay = cy_c[CW-1] ? CW'(-cy_c) : CW'(cy_c);
    assign az = cz_c[CW-1] ? CW'(-cz_c) : CW'(cz_c);
    assign delta     = W'(r_r1) - W'(r_r0);
    assign delta_mag = delta[W-1] ? RUW'(-delta) : RUW'(delta);

    assign fl_c.zero_axis = zero_c;
    assign fl_c.behind    = d_c[DW-1];
    assign fl_c.past      = d_c > h2_c;

    pcft_mul #(.AW(CW), .BW(CW)) u_sq_x (
        .i_clk(i_clk), .i_en(en), .i_a(ax), .i_b(ax), .o_p(sq_x));
    pcft_mul #(.AW(CW), .BW(CW)) u_sq_y (
        .i_clk(i_clk), .i_en(en), .i_a(ay), .i_b(ay), .o_p(sq_y));
    pcft_mul #(.AW(CW), .BW(CW)) u_sq_z (
        .i_clk(i_clk), .i_en(en), .i_a(az), .i_b(az), .o_p(sq_z));
    pcft_mul #(.AW(RUW), .BW(HUW)) u_r0h2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_r0), .i_b(h2_c[HUW-1:0]), .o_p(r0h2));
    pcft_mul #(.AW(RUW), .BW(HUW)) u_rdd (
        .i_clk(i_clk), .i_en(en), .i_a(delta_mag), .i_b(d_c[HUW-1:0]), .o_p(rdd));

    logic                   r_vd, r_ve, r_vf, r_vg, r_vh;
    t_flags                 r_fl_d, r_fl_e, r_fl_f, r_fl_g, r_fl_h;
    logic [HUW-1:0]         r_h2_d, r_h2_e, r_h2_f;
    logic [CRW-1:0]         r_cr;
    logic [RW-1:0]          r_rr;
    logic signed [RW:0]     n_rr;
    logic [LW-1:0]          lhs;
    logic [R2W-1:0]         rr2;
    t_region                n_region;

    // stage F: sum of squares and radius at the projection, both scaled by h^2
    assign n_rr = delta[W-1] ? ((RW+1)'(r0h2) - (RW+1)'(rdd))
                             : ((RW+1)'(r0h2) + (RW+1)'(rdd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd        <= 1'b0;
            r_ve        <= 1'b0;
            r_vf        <= 1'b0;
            r_vg        <= 1'b0;
            r_vh        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vd        <= vc;
            r_ve        <= r_vd;
            r_vf        <= r_ve;
            r_vg        <= r_vf;
            r_vh        <= r_vg;
            r_out_valid <= r_vh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl_d <= fl_c;
            r_fl_e <= r_fl_d;
            r_fl_f <= r_fl_e;
            r_fl_g <= r_fl_f;
            r_fl_h <= r_fl_g;
            r_h2_d <= h2_c[HUW-1:0];
            r_h2_e <= r_h2_d;
            r_h2_f <= r_h2_e;
            r_cr   <= CRW'(sq_x) + CRW'(sq_y) + CRW'(sq_z);
            r_rr   <= n_rr[RW-1:0];
            r_region <= n_region;
        end
    end

    // stages G..H: final cross-multiplied terms
    pcft_mul #(.AW(CRW), .BW(HUW)) u_lhs (
        .i_clk(i_clk), .i_en(en), .i_a(r_cr), .i_b(r_h2_f), .o_p(lhs));
    pcft_mul #(.AW(RW), .BW(RW)) u_rr2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_rr), .i_b(r_rr), .o_p(rr2));

    always_comb begin
        if (r_fl_h.zero_axis) begin
            n_region = REGION_OUTSIDE;
        end else if (r_fl_h.behind) begin
            n_region = REGION_BEFORE;
        end else if (r_fl_h.past) begin
            n_region = REGION_PAST;
        end else if (lhs <= LW'(rr2)) begin
            n_region = REGION_INSIDE;
        end else begin
            n_region = REGION_OUTSIDE;
        end
    end

    a_zero_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vh && r_fl_h.zero_axis |=> r_region == REGION_OUTSIDE)
        else $error("zero-length axis not reported as outside");

    a_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vh && !r_fl_h.zero_axis && r_fl_h.behind |=> r_region == REGION_BEFORE)
        else $error("point before first end misclassified");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable({r_vd, r_ve, r_vf, r_vg, r_vh, r_out_valid}))
        else $error("pipeline valid bits moved while held");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vh && r_fl_h.past |-> !r_fl_h.behind)
        else $error("past and before flags both set");

endmodule

// ===== sv/pcft_mul.sv =====
// ----------------------------------------------------------------------------
// pcft_mul
// Two-stage unsigned multiplier: 32x32 partial products, then a summing stage.
// ----------------------------------------------------------------------------
module pcft_mul #(
    parameter int unsigned AW = 64,
    parameter int unsigned BW = 64
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [AW-1:0]      i_a,
    input  logic [BW-1:0]      i_b,
    output logic [AW+BW-1:0]   o_p
);
    import pcft_pkg::*;

    localparam int unsigned NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int unsigned NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int unsigned APW = NA * MUL_CHUNK;
    localparam int unsigned BPW = NB * MUL_CHUNK;
    localparam int unsigned SW  = APW + BPW;
    localparam int unsigned PW  = AW + BW;

    logic [APW-1:0]             a_pad;
    logic [BPW-1:0]             b_pad;
    logic [2*MUL_CHUNK-1:0]     r_pp [NA*NB];
    logic [SW-1:0]              n_sum;
    logic [PW-1:0]              r_p;

    assign a_pad = APW'(i_a);
    assign b_pad = BPW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= (2*MUL_CHUNK)'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                                  * (2*MUL_CHUNK)'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SW'(r_pp[i*NB+j]) << ((i + j) * MUL_CHUNK));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[PW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ===== sv/pcft_front.sv =====
// ----------------------------------------------------------------------------
// pcft_front
// Offset, axis products and dot/cross sums: three register stages.
// ----------------------------------------------------------------------------
module pcft_front #(
    parameter int unsigned W = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [W-1:0]     i_px,
    input  logic signed [W-1:0]     i_py,
    input  logic signed [W-1:0]     i_pz,
    input  logic signed [W-1:0]     i_e0x,
    input  logic signed [W-1:0]     i_e0y,
    input  logic signed [W-1:0]     i_e0z,
    input  logic signed [W-1:0]     i_e1x,
    input  logic signed [W-1:0]     i_e1y,
    input  logic signed [W-1:0]     i_e1z,
    output logic                    o_valid,
    output logic                    o_zero,
    output logic signed [2*W+3:0]   o_d,
    output logic signed [2*W+3:0]   o_h2,
    output logic signed [2*W+2:0]   o_cx,
    output logic signed [2*W+2:0]   o_cy,
    output logic signed [2*W+2:0]   o_cz
);
    localparam int unsigned AV = W + 1;
    localparam int unsigned PW = 2 * AV;
    localparam int unsigned DW = 2 * W + 4;
    localparam int unsigned CW = 2 * W + 3;

    logic                   r_va, r_vb, r_vc;
    logic signed [AV-1:0]   r_v [3];
    logic signed [AV-1:0]   r_a [3];
    logic signed [PW-1:0]   r_pd [3];
    logic signed [PW-1:0]   r_ph [3];
    logic signed [PW-1:0]   r_c1 [3];
    logic signed [PW-1:0]   r_c2 [3];
    logic                   r_zero_b, r_zero_c;
    logic signed [DW-1:0]   r_d, r_h2;
    logic signed [CW-1:0]   r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0] <= AV'(i_px) - AV'(i_e0x);
            r_v[1] <= AV'(i_py) - AV'(i_e0y);
            r_v[2] <= AV'(i_pz) - AV'(i_e0z);
            r_a[0] <= AV'(i_e1x) - AV'(i_e0x);
            r_a[1] <= AV'(i_e1y) - AV'(i_e0y);
            r_a[2] <= AV'(i_e1z) - AV'(i_e0z);

            for (int k = 0; k < 3; k++) begin
                r_pd[k] <= PW'(r_v[k]) * PW'(r_a[k]);
                r_ph[k] <= PW'(r_a[k]) * PW'(r_a[k]);
            end
            r_c1[0] <= PW'(r_v[1]) * PW'(r_a[2]);
            r_c2[0] <= PW'(r_v[2]) * PW'(r_a[1]);
            r_c1[1] <= PW'(r_v[2]) * PW'(r_a[0]);
            r_c2[1] <= PW'(r_v[0]) * PW'(r_a[2]);
            r_c1[2] <= PW'(r_v[0]) * PW'(r_a[1]);
            r_c2[2] <= PW'(r_v[1]) * PW'(r_a[0]);
            r_zero_b <= (r_a[0] == '0) && (r_a[1] == '0) && (r_a[2] == '0);

            r_d  <= DW'(r_pd[0]) + DW'(r_pd[1]) + DW'(r_pd[2]);
            r_h2 <= DW'(r_ph[0]) + DW'(r_ph[1]) + DW'(r_ph[2]);
            r_cx <= CW'(r_c1[0]) - CW'(r_c2[0]);
            r_cy <= CW'(r_c1[1]) - CW'(r_c2[1]);
            r_cz <= CW'(r_c1[2]) - CW'(r_c2[2]);
            r_zero_c <= r_zero_b;
        end
    end

    assign o_valid = r_vc;
    assign o_zero  = r_zero_c;
    assign o_d     = r_d;
    assign o_h2    = r_h2;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_cz    = r_cz;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the truncated cone point classifier: programs the
// cone over the APB port, streams directed and random points with random
// idling and a long output hold-off, and compares each region against an
// exact wide-integer prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import pcft_pkg::*;

    localparam int CW = 24;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [4:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic signed [CW-1:0] i_point_x, i_point_y, i_point_z;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_region;

    point_in_cone_frustum_test #(.COORD_WIDTH(CW)) u_top (.*);

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic                 has_exp;
        t_region              exp;
    } t_point_row;

    logic signed [CW-1:0] cone_e0 [3];
    logic signed [CW-1:0] cone_e1 [3];
    logic [CW-2:0]        cone_r0, cone_r1;

    t_region region_q [$];
    int      n_errors;
    int      n_checked;
    int      n_sent;
    bit      hold_mode;
    bit      calm_in, calm_out;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_region classify(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                         logic signed [CW-1:0] pz);
        logic signed [255:0] a [3];
        logic signed [255:0] v [3];
        logic signed [255:0] d, h2, cx, cy, cz, cr, lhs, rr;
        logic signed [CW-1:0] p [3];
        p[0] = px; p[1] = py; p[2] = pz;
        for (int i = 0; i < 3; i++) begin
            a[i] = 256'(signed'(cone_e1[i])) - 256'(signed'(cone_e0[i]));
            v[i] = 256'(signed'(p[i])) - 256'(signed'(cone_e0[i]));
        end
        d  = v[0]*a[0] + v[1]*a[1] + v[2]*a[2];
        h2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        if (a[0] == 0 && a[1] == 0 && a[2] == 0) return REGION_OUTSIDE;
        if (d < 0) return REGION_BEFORE;
        if (d > h2) return REGION_PAST;
        cx = v[1]*a[2] - v[2]*a[1];
        cy = v[2]*a[0] - v[0]*a[2];
        cz = v[0]*a[1] - v[1]*a[0];
        cr = cx*cx + cy*cy + cz*cz;
        lhs = cr * h2;
        rr = $signed({233'd0, cone_r0}) * h2
           + ($signed({233'd0, cone_r1}) - $signed({233'd0, cone_r0})) * d;
        return (lhs <= rr*rr) ? REGION_INSIDE : REGION_OUTSIDE;
    endfunction

    task automatic apb_write(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 5'(idx) << 2; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            CFG_END0_X:       cone_e0[0] = val[CW-1:0];
            CFG_END0_Y:       cone_e0[1] = val[CW-1:0];
            CFG_END0_Z:       cone_e0[2] = val[CW-1:0];
            CFG_END1_X:       cone_e1[0] = val[CW-1:0];
            CFG_END1_Y:       cone_e1[1] = val[CW-1:0];
            CFG_END1_Z:       cone_e1[2] = val[CW-1:0];
            CFG_RADIUS_START: cone_r0 = val[CW-2:0];
            default:          cone_r1 = val[CW-2:0];
        endcase
    endtask

    task automatic set_cone(int e0x, int e0y, int e0z, int e1x, int e1y, int e1z,
                            int r0, int r1);
        apb_write(CFG_END0_X, e0x);
        apb_write(CFG_END0_Y, e0y);
        apb_write(CFG_END0_Z, e0z);
        apb_write(CFG_END1_X, e1x);
        apb_write(CFG_END1_Y, e1y);
        apb_write(CFG_END1_Z, e1z);
        apb_write(CFG_RADIUS_START, r0);
        apb_write(CFG_RADIUS_END, r1);
    endtask

    task automatic drain();
        while (region_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // a point is presented at the falling edge and held until accepted
    task automatic send_point(t_point_row row);
        while (!calm_in && $urandom_range(99) < 9) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_point_x = row.x; i_point_y = row.y; i_point_z = row.z;
        begin
            t_region e;
            e = classify(row.x, row.y, row.z);
            if (row.has_exp && e != row.exp) begin
                $error("predictor region expected %0d got %0d", row.exp, e);
                n_errors++;
            end
            region_q.push_back(row.has_exp ? row.exp : e);
        end
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rnd_coord(int span);
        case ($urandom_range(9))
            0:       return CW'($urandom);
            1:       return {1'b0, {(CW-1){1'b1}}};
            2:       return {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(2*span)) - span);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (region_q.size() == 0) begin
                $error("region %0d with no request outstanding", o_region);
                n_errors++;
            end else begin
                t_region e;
                e = region_q.pop_front();
                n_checked++;
                if (o_region !== e) begin
                    $error("region expected %0d actual %0d", e, o_region);
                    n_errors++;
                end
            end
        end
    end

    // output stall: random, with one long hold-off and a calm stretch
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_mode) begin
                i_out_stall = 1'b1;
                repeat (60) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_mode = 1'b0;
            end else begin
                i_out_stall = !calm_out && ($urandom_range(99) < 9);
            end
        end
    end

    t_point_row rows [];

    initial begin
        t_point_row r;
        int span;
        n_errors = 0; n_checked = 0; n_sent = 0;
        hold_mode = 0; calm_in = 0; calm_out = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_in_valid = 0; i_point_x = '0; i_point_y = '0; i_point_z = '0;
        for (int i = 0; i < 3; i++) begin
            cone_e0[i] = '0; cone_e1[i] = '0;
        end
        cone_r0 = '0; cone_r1 = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero-length axis after reset
        rows = '{
            '{'0, '0, '0, 1, REGION_OUTSIDE},
            '{24'h7fffff, 24'h800000, 24'h123456, 1, REGION_OUTSIDE}
        };
        foreach (rows[i]) send_point(rows[i]);
        drain();

        // cylinder along x from 0 to 10.0, radius 2.0
        set_cone(0, 0, 0, 2560, 0, 0, 512, 512);
        rows = '{
            '{-1, 0, 0, 1, REGION_BEFORE},
            '{2561, 0, 0, 1, REGION_PAST},
            '{1280, 0, 0, 1, REGION_INSIDE},
            '{0, 512, 0, 1, REGION_INSIDE},
            '{2560, 0, 512, 1, REGION_INSIDE},
            '{1280, 513, 0, 1, REGION_OUTSIDE},
            '{24'h800000, 0, 0, 1, REGION_BEFORE},
            '{24'h7fffff, 0, 0, 1, REGION_PAST},
            '{1280, 24'h7fffff, 24'h800000, 1, REGION_OUTSIDE},
            '{100, 300, -300, 0, REGION_INSIDE}
        };
        foreach (rows[i]) send_point(rows[i]);
        drain();

        // extreme ends and radii
        set_cone(32'hff800000, 32'h007fffff, 32'hff800000,
                 32'h007fffff, 32'hff800000, 32'h007fffff, 32'h7fffff, 0);
        rows = '{
            '{0, 0, 0, 1, REGION_INSIDE},
            '{24'h800000, 24'h7fffff, 24'h800000, 0, REGION_INSIDE},
            '{24'h7fffff, 24'h800000, 24'h7fffff, 0, REGION_INSIDE},
            '{24'h7fffff, 24'h7fffff, 24'h7fffff, 0, REGION_INSIDE},
            '{24'h555555, 24'haaaaaa, 24'h0f0f0f, 0, REGION_INSIDE}
        };
        foreach (rows[i]) send_point(rows[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            span = (ph < 3) ? 4096 : 8388607;
            set_cone(rnd_coord(span), rnd_coord(span), rnd_coord(span),
                     rnd_coord(span), rnd_coord(span), rnd_coord(span),
                     (ph == 5) ? 0 : $urandom_range(span / 2),
                     (ph == 4) ? 23'h7fffff : $urandom_range(span / 2));
            calm_in = (ph == 2); calm_out = (ph == 2);
            if (ph == 1) hold_mode = 1'b1;
            for (int k = 0; k < 200; k++) begin
                r.has_exp = 0; r.exp = REGION_INSIDE;
                if (ph >= 3 && $urandom_range(3) == 0) begin
                    // near the axis so all four regions show up
                    r.x = CW'(cone_e0[0] + (cone_e1[0] - cone_e0[0]) / 4
                              * int'($urandom_range(5))
                              + int'($urandom_range(2000)) - 1000);
                    r.y = CW'(cone_e0[1] + (cone_e1[1] - cone_e0[1]) / 4
                              * int'($urandom_range(5)));
                    r.z = CW'(cone_e0[2] + (cone_e1[2] - cone_e0[2]) / 4
                              * int'($urandom_range(5)));
                end else begin
                    r.x = rnd_coord(span); r.y = rnd_coord(span); r.z = rnd_coord(span);
                end
                send_point(r);
            end
            calm_in = 0; calm_out = 0;
            drain();
        end

        $display("Sent %0d points over 9 cone settings, %0d regions checked.",
                 n_sent, n_checked);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pcft_pkg.sv
sv/pcft_mul.sv
sv/pcft_front.sv
sv/point_in_cone_frustum_test.sv
tb/tb_top.sv
